/* design/clsu_pkg.sv */
`default_nettype none
package clsu_pkg;
    localparam int unsigned MemBytesDefault = 65536;

    localparam logic [4:0] OP_LDA = 5'd0;
    localparam logic [4:0] OP_LDX = 5'd1;
    localparam logic [4:0] OP_LDY = 5'd2;
    localparam logic [4:0] OP_STA = 5'd3;
    localparam logic [4:0] OP_STX = 5'd4;
    localparam logic [4:0] OP_STY = 5'd5;
    localparam logic [4:0] OP_TAX = 5'd6;
    localparam logic [4:0] OP_TAY = 5'd7;
    localparam logic [4:0] OP_TXA = 5'd8;
    localparam logic [4:0] OP_TYA = 5'd9;
    localparam logic [4:0] OP_TSX = 5'd10;
    localparam logic [4:0] OP_TXS = 5'd11;
    localparam logic [4:0] OP_PHA = 5'd12;
    localparam logic [4:0] OP_PHP = 5'd13;
    localparam logic [4:0] OP_PLA = 5'd14;
    localparam logic [4:0] OP_PLP = 5'd15;
    localparam logic [4:0] OP_AND = 5'd16;
    localparam logic [4:0] OP_EOR = 5'd17;
    localparam logic [4:0] OP_ORA = 5'd18;
    localparam logic [4:0] OP_BIT = 5'd19;
    localparam logic [4:0] OP_HWR = 5'd20;
    localparam logic [4:0] OP_HRD = 5'd21;

    localparam logic [3:0] MD_IMM = 4'd0;
    localparam logic [3:0] MD_ZP  = 4'd1;
    localparam logic [3:0] MD_ZPX = 4'd2;
    localparam logic [3:0] MD_ZPY = 4'd3;
    localparam logic [3:0] MD_ABS = 4'd4;
    localparam logic [3:0] MD_ABX = 4'd5;
    localparam logic [3:0] MD_ABY = 4'd6;
    localparam logic [3:0] MD_INX = 4'd7;
    localparam logic [3:0] MD_INY = 4'd8;
    localparam logic [3:0] MD_IMP = 4'd9;

    localparam logic [7:0] FLAG_N = 8'h80;
    localparam logic [7:0] FLAG_V = 8'h40;
    localparam logic [7:0] FLAG_Z = 8'h02;
    localparam logic [7:0] FLAGS_RESET = 8'h04;
    localparam logic [7:0] STACK_PAGE = 8'h01;

    typedef struct packed {
        logic       we;
        logic       re;
        logic [15:0] addr;
        logic [7:0] wdata;
    } t_mem_req;

    function automatic logic legal_mode(input logic [4:0] op, input logic [3:0] md);
        logic [9:0] m;
        begin
            m = 10'h000;
            case (op)
                OP_LDA, OP_AND, OP_EOR, OP_ORA: m = 10'h1F7;
                OP_LDX: m = 10'h05B;
                OP_LDY: m = 10'h037;
                OP_STA: m = 10'h1F6;
                OP_STX: m = 10'h01A;
                OP_STY: m = 10'h016;
                OP_BIT: m = 10'h012;
                default: m = (op >= OP_TAX && op <= OP_PLP) ? 10'h200 : 10'h000;
            endcase
            legal_mode = (md <= MD_IMP) ? m[md] : 1'b0;
        end
    endfunction

    function automatic logic [2:0] load_cycles(input logic [3:0] md);
        begin
            case (md)
                MD_IMM: load_cycles = 3'd2;
                MD_ZP: load_cycles = 3'd3;
                MD_INX: load_cycles = 3'd6;
                MD_INY: load_cycles = 3'd5;
                default: load_cycles = 3'd4;
            endcase
        end
    endfunction

    function automatic logic [2:0] store_cycles(input logic [3:0] md);
        begin
            case (md)
                MD_ZP: store_cycles = 3'd3;
                MD_ABX, MD_ABY: store_cycles = 3'd5;
                MD_INX, MD_INY: store_cycles = 3'd6;
                default: store_cycles = 3'd4;
            endcase
        end
    endfunction
endpackage
`default_nettype wire

/* design/clsu_mem.sv */
`default_nettype none
module clsu_mem #(
    parameter int unsigned MEM_BYTES = clsu_pkg::MemBytesDefault
) (
    input  wire logic              i_clk,
    input  wire clsu_pkg::t_mem_req i_req,
    output logic [7:0]             o_rdata
);
    import clsu_pkg::*;
    localparam int unsigned AW = $clog2(MEM_BYTES);
    logic [7:0] r_mem [MEM_BYTES];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr[AW-1:0]] <= i_req.wdata;
        end
        if (i_req.re) begin
            o_rdata <= r_mem[i_req.addr[AW-1:0]];
        end
    end
endmodule
`default_nettype wire

/* design/cpu_load_store_logic_unit.sv */
`default_nettype none
// Executes one decoded load, store, transfer, stack, logic or direct memory
// access instruction per item against internal registers and a byte memory,
// and reports registers, status, the data byte involved, the instruction cycle count and an error.
// Input channel: i_valid / o_stall with operation, mode, operand, write_data.
// Output channel: o_valid / i_stall with the result fields.
// An item is accepted when valid is high and stall is low. The block works
// on one item at a time; o_stall is high from the cycle after acceptance
// until its result has been taken. After acceptance an item passes through
// the address, data and execute states to its result; in the indirect modes
// the two pointer bytes are first read through the single registered memory
// port before the address is formed. The block returns to idle in the cycle
// after the result is taken, so a new item is accepted only once the previous result has gone.
// When the receiver stalls, the result holds and no new item is taken.
// Synchronous reset clears the registers (status to irq disable set) and
// the handshake state; memory contents are undefined until written.
module cpu_load_store_logic_unit #(
    parameter int unsigned MEM_BYTES = clsu_pkg::MemBytesDefault
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [4:0]  i_operation,
    input  wire logic [3:0]  i_mode,
    input  wire logic [15:0] i_operand,
    input  wire logic [7:0]  i_write_data,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_acc_value,
    output logic [7:0]       o_x_value,
    output logic [7:0]       o_y_value,
    output logic [7:0]       o_stack_value,
    output logic [7:0]       o_flags_value,
    output logic [7:0]       o_read_data,
    output logic [2:0]       o_cycle_count,
    output logic             o_error
);
    import clsu_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PTR0 = 3'd1;
    localparam logic [2:0] S_PTR1 = 3'd2;
    localparam logic [2:0] S_ADDR = 3'd3;
    localparam logic [2:0] S_DATA = 3'd4;
    localparam logic [2:0] S_EXEC = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]  r_state, n_state;
    logic [7:0]  r_a, r_x, r_y, r_sp, r_p;
    logic [4:0]  r_op;
    logic [3:0]  r_md;
    logic [15:0] r_opd, r_ea;
    logic [7:0]  r_wd, r_lo, r_data;
    logic [2:0]  r_cyc;
    logic        r_err, r_cross;
    logic [7:0]  w_rdata;
    t_mem_req    w_req, w_exec_req;

    // Shared 16-bit adder for the second pointer byte address and the zero-page and absolute indexed addresses.
    logic [15:0] w_add_a, w_add_b, w_sum;
    assign w_sum = w_add_a + w_add_b;

    logic [7:0] w_zp_ptr;
    assign w_zp_ptr = r_opd[7:0] + ((r_md == MD_INX) ? r_x : 8'h00);

    always_comb begin
        w_add_a = 16'h0000;
        w_add_b = 16'h0000;
        case (r_state)
            S_PTR1: begin
                w_add_a = {8'h00, r_ea[7:0]};
                w_add_b = 16'h0001;
            end
            S_ADDR: begin
                w_add_a = r_ea;
                w_add_b = {8'h00, (r_md == MD_ABX || r_md == MD_ZPX) ? r_x : r_y};
            end
            default: begin
                w_add_a = 16'h0000;
                w_add_b = 16'h0000;
            end
        endcase
    end

    always_comb begin
        w_req = '0;
        case (r_state)
            S_PTR0: begin
                w_req.re = 1'b1;
                w_req.addr = {8'h00, w_zp_ptr};
            end
            S_PTR1: begin
                w_req.re = 1'b1;
                w_req.addr = {8'h00, w_sum[7:0]};
            end
            S_DATA: begin
                w_req.re = 1'b1;
                w_req.addr = r_ea;
            end
            default: w_req = '0;
        endcase
    end

    clsu_mem #(.MEM_BYTES(MEM_BYTES)) u_mem (
        .i_clk  (i_clk),
        .i_req  (w_exec_req),
        .o_rdata(w_rdata)
    );

    logic     w_oob;
    logic     w_is_load;
    logic [7:0] w_m, w_res, w_sd;
    assign w_oob = (32'(r_ea) >= 32'(MEM_BYTES));
    assign w_is_load = (r_op <= OP_LDY) || (r_op >= OP_AND && r_op <= OP_BIT);
    assign w_m = (r_md == MD_IMM) ? r_opd[7:0] : w_rdata;
    assign w_sd = (r_op == OP_STA) ? r_a : ((r_op == OP_STX) ? r_x : r_y);

    always_comb begin
        w_exec_req = w_req;
        if (r_state == S_EXEC && !r_err) begin
            if (r_op == OP_HWR) begin
                w_exec_req.we = 1'b1;
                w_exec_req.addr = r_ea;
                w_exec_req.wdata = r_wd;
            end else if (r_op >= OP_STA && r_op <= OP_STY) begin
                w_exec_req.we = 1'b1;
                w_exec_req.addr = r_ea;
                w_exec_req.wdata = w_sd;
            end else if (r_op == OP_PHA || r_op == OP_PHP) begin
                w_exec_req.we = 1'b1;
                w_exec_req.addr = {STACK_PAGE, r_sp};
                w_exec_req.wdata = (r_op == OP_PHA) ? r_a : (r_p | 8'h30);
            end
        end
    end

    always_comb begin
        case (r_op)
            OP_AND: w_res = r_a & w_m;
            OP_EOR: w_res = r_a ^ w_m;
            OP_ORA: w_res = r_a | w_m;
            default: w_res = w_m;
        endcase
    end

    function automatic logic [7:0] nz(input logic [7:0] p, input logic [7:0] v);
        nz = (p & ~(FLAG_N | FLAG_Z)) | (v & FLAG_N) | ((v == 8'h00) ? FLAG_Z : 8'h00);
    endfunction

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_DONE);
    assign o_acc_value = r_a;
    assign o_x_value = r_x;
    assign o_y_value = r_y;
    assign o_stack_value = r_sp;
    assign o_flags_value = r_p;
    assign o_read_data = r_data;
    assign o_cycle_count = r_cyc;
    assign o_error = r_err;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_operation != OP_HWR && i_operation != OP_HRD
                        && (i_mode == MD_INX || i_mode == MD_INY)) begin
                        n_state = S_PTR0;
                    end else begin
                        n_state = S_ADDR;
                    end
                end
            end
            S_PTR0: n_state = S_PTR1;
            S_PTR1: n_state = S_ADDR;
            S_ADDR: n_state = S_DATA;
            S_DATA: n_state = S_EXEC;
            S_EXEC: n_state = S_DONE;
            S_DONE: if (!i_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_a <= 8'h00;
            r_x <= 8'h00;
            r_y <= 8'h00;
            r_sp <= 8'h00;
            r_p <= FLAGS_RESET;
            r_err <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_op <= i_operation;
                        r_md <= i_mode;
                        r_opd <= i_operand;
                        r_wd <= i_write_data;
                        r_cross <= 1'b0;
                        r_err <= !(i_operation == OP_HWR || i_operation == OP_HRD
                                   || legal_mode(i_operation, i_mode));
                        if (i_operation == OP_HWR || i_operation == OP_HRD
                            || i_mode == MD_ABS || i_mode == MD_ABX || i_mode == MD_ABY) begin
                            r_ea <= i_operand;
                        end else begin
                            r_ea <= {8'h00, i_operand[7:0]};
                        end
                    end
                end
                S_PTR0: r_ea <= {8'h00, w_zp_ptr};
                S_PTR1: r_lo <= w_rdata;
                S_ADDR: begin
                    if (r_op != OP_HWR && r_op != OP_HRD) begin
                        if (r_md == MD_INX || r_md == MD_INY) begin
                            r_ea <= (r_md == MD_INY) ? ({w_rdata, r_lo} + {8'h00, r_y})
                                                     : {w_rdata, r_lo};
                            r_cross <= (r_md == MD_INY)
                                       && ((17'({8'h00, r_lo}) + 17'({9'h000, r_y}))
                                           > 17'h0FF);
                        end else if (r_md == MD_ZPX || r_md == MD_ZPY) begin
                            r_ea <= {8'h00, w_sum[7:0]};
                        end else if (r_md == MD_ABX || r_md == MD_ABY) begin
                            r_ea <= w_sum;
                            r_cross <= (w_sum[15:8] != r_ea[15:8]);
                        end else if (r_op == OP_PLA || r_op == OP_PLP) begin
                            r_ea <= {STACK_PAGE, r_sp + 8'h01};
                        end
                    end
                end
                S_DATA: begin
                    if (!r_err && w_oob && (r_op == OP_HWR || r_op == OP_HRD
                        || (r_md >= MD_ZP && r_md <= MD_INY))) begin
                        r_err <= 1'b1;
                    end
                end
                S_EXEC: begin
                    if (r_err) begin
                        r_data <= 8'h00;
                        r_cyc <= 3'd0;
                    end else begin
                        if (r_op == OP_HWR) begin
                            r_data <= r_wd;
                            r_cyc <= 3'd0;
                        end else if (r_op == OP_HRD) begin
                            r_data <= w_rdata;
                            r_cyc <= 3'd0;
                        end else if (w_is_load) begin
                            r_data <= w_m;
                            r_cyc <= load_cycles(r_md) + {2'b00, r_cross};
                            case (r_op)
                                OP_LDX: begin
                                    r_x <= w_m;
                                    r_p <= nz(r_p, w_m);
                                end
                                OP_LDY: begin
                                    r_y <= w_m;
                                    r_p <= nz(r_p, w_m);
                                end
                                OP_BIT: begin
                                    r_p <= (r_p & ~(FLAG_N | FLAG_V | FLAG_Z))
                                           | (w_m & (FLAG_N | FLAG_V))
                                           | (((r_a & w_m) == 8'h00) ? FLAG_Z : 8'h00);
                                end
                                default: begin
                                    r_a <= w_res;
                                    r_p <= nz(r_p, w_res);
                                end
                            endcase
                        end else if (r_op <= OP_STY) begin
                            r_data <= w_sd;
                            r_cyc <= store_cycles(r_md);
                        end else if (r_op <= OP_TXS) begin
                            r_cyc <= 3'd2;
                            case (r_op)
                                OP_TAX: begin
                                    r_x <= r_a; r_data <= r_a; r_p <= nz(r_p, r_a);
                                end
                                OP_TAY: begin
                                    r_y <= r_a; r_data <= r_a; r_p <= nz(r_p, r_a);
                                end
                                OP_TXA: begin
                                    r_a <= r_x; r_data <= r_x; r_p <= nz(r_p, r_x);
                                end
                                OP_TYA: begin
                                    r_a <= r_y; r_data <= r_y; r_p <= nz(r_p, r_y);
                                end
                                OP_TSX: begin
                                    r_x <= r_sp; r_data <= r_sp; r_p <= nz(r_p, r_sp);
                                end
                                default: begin
                                    r_sp <= r_x; r_data <= r_x;
                                end
                            endcase
                        end else if (r_op <= OP_PHP) begin
                            r_data <= (r_op == OP_PHA) ? r_a : (r_p | 8'h30);
                            r_sp <= r_sp - 8'h01;
                            r_cyc <= 3'd3;
                        end else begin
                            r_sp <= r_sp + 8'h01;
                            r_data <= w_rdata;
                            r_cyc <= 3'd4;
                            if (r_op == OP_PLA) begin
                                r_a <= w_rdata;
                                r_p <= nz(r_p, w_rdata);
                            end else begin
                                r_p <= w_rdata & 8'hCF;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error |-> o_cycle_count == 3'd0 && o_read_data == 8'h00)
        else $error("error result carries data");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_acc_value) && $stable(o_flags_value))
        else $error("stalled result changed");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exec_req.we |-> r_state == S_EXEC && !r_err)
        else $error("memory write outside execute");
endmodule
`default_nettype wire
